FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the FASTA record scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FRS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define FRS_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define FRS_ASSERT(lbl, clk, rst, prop)
`define FRS_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: rtl/core/frs_pkg.sv
// Types and constants shared by the FASTA record scanner modules.
`timescale 1ns / 1ps
`default_nettype none
package frs_pkg;
  localparam int unsigned POSITION_BITS_DEFAULT = 40;
  localparam int unsigned OUT_POS_BITS          = 40;
  localparam int unsigned RECORD_BITS           = 32;
  localparam int unsigned BYTE_BITS             = 8;
  localparam int unsigned QUEUE_DEPTH           = 2;

  localparam logic [BYTE_BITS-1:0] CHAR_MARKER  = 8'h3E;
  localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    OP_TEXT    = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_OPEN    = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     last;
  } op_ctl_t;

  typedef struct packed {
    logic final_pending;
  } back_stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/frs_front.sv
// Front end: accept bytes, track position and line start, classify each item.
`timescale 1ns / 1ps
`default_nettype none
module frs_front #(
  parameter int unsigned POSITION_BITS = frs_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [frs_pkg::BYTE_BITS-1:0]  data_byte,
  input  wire logic                           stream_end,
  output logic                                op_push,
  output frs_pkg::op_ctl_t                    op_ctl,
  output logic [POSITION_BITS-1:0]            op_pos,
  input  wire logic                           op_full
);
  import frs_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] pos_inc;
  logic                     at_line_start;
  logic                     accept;

  assign in_ready = !op_full;
  assign accept   = in_valid && !op_full;
  assign op_push  = accept;

  // Saturate at the top of the position range.
  assign pos_inc = (byte_position == POS_MAX) ? byte_position : byte_position + 1'b1;
  assign op_pos  = pos_inc;

  always_comb begin
    op_ctl.last = stream_end;
    if (at_line_start && data_byte == CHAR_MARKER) begin
      op_ctl.kind = OP_OPEN;
    end else if (data_byte == CHAR_NEWLINE) begin
      op_ctl.kind = OP_NEWLINE;
    end else begin
      op_ctl.kind = OP_TEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      at_line_start <= 1'b1;
    end else if (accept) begin
      if (stream_end) begin
        byte_position <= '0;
        at_line_start <= 1'b1;
      end else begin
        byte_position <= pos_inc;
        at_line_start <= (data_byte == CHAR_NEWLINE);
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/frs_queue.sv
// Short FIFO that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none
module frs_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data,
  input  wire logic             pop
);
  import frs_pkg::*;

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  logic [WIDTH-1:0]    store [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == CNT_FULL);
  assign pop_valid = (count != '0);
  assign pop_data  = store[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/frs_back.sv
// Back end: record state, length counters and the registered result item.
`timescale 1ns / 1ps
`default_nettype none
module frs_back #(
  parameter int unsigned POSITION_BITS = frs_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               op_valid,
  input  wire frs_pkg::op_ctl_t                   op_ctl,
  input  wire logic [POSITION_BITS-1:0]           op_pos,
  output logic                                    op_pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [frs_pkg::RECORD_BITS-1:0]         record_number,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        header_start,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        header_length,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        sequence_start,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        sequence_length,
  output logic                                    final_record,
  output frs_pkg::back_stat_t                     stat
);
  import frs_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  logic                     record_open, record_open_next;
  logic                     in_sequence, in_sequence_next;
  logic                     final_pending, final_pending_next;
  logic [RECORD_BITS-1:0]   record_count, record_count_next;
  logic [POSITION_BITS-1:0] cur_hs, cur_hs_next;
  logic [POSITION_BITS-1:0] cur_hl, cur_hl_next;
  logic [POSITION_BITS-1:0] cur_ss, cur_ss_next;
  logic [POSITION_BITS-1:0] cur_sl, cur_sl_next;

  logic                     slot_free;
  logic                     emit;
  logic                     emit_final;
  logic [RECORD_BITS-1:0]   e_num;
  logic [POSITION_BITS-1:0] e_hs, e_hl, e_ss, e_sl;

  assign slot_free = !out_valid || out_ready;
  assign stat.final_pending = final_pending;

  always_comb begin
    record_open_next   = record_open;
    in_sequence_next   = in_sequence;
    final_pending_next = final_pending;
    record_count_next  = record_count;
    cur_hs_next        = cur_hs;
    cur_hl_next        = cur_hl;
    cur_ss_next        = cur_ss;
    cur_sl_next        = cur_sl;
    emit       = 1'b0;
    emit_final = 1'b0;
    op_pop     = 1'b0;
    e_num = record_count;
    e_hs  = cur_hs;
    e_hl  = cur_hl;
    e_ss  = cur_ss;
    e_sl  = cur_sl;

    if (final_pending) begin
      // Second item of a marker on the last byte: drain the new record, then clear.
      if (slot_free) begin
        emit       = 1'b1;
        emit_final = 1'b1;
        final_pending_next = 1'b0;
        record_open_next   = 1'b0;
        in_sequence_next   = 1'b0;
        record_count_next  = '0;
        cur_hs_next = '0;
        cur_hl_next = '0;
        cur_ss_next = '0;
        cur_sl_next = '0;
      end
    end else if (op_valid && slot_free) begin
      op_pop = 1'b1;
      if (op_ctl.kind == OP_OPEN) begin
        if (record_open) begin
          emit = 1'b1;
          record_count_next = record_count + 1'b1;
        end
        record_open_next = 1'b1;
        in_sequence_next = 1'b0;
        cur_hs_next = op_pos;
        cur_hl_next = '0;
        cur_ss_next = '0;
        cur_sl_next = '0;
      end else if (record_open) begin
        if (op_ctl.kind != OP_NEWLINE) begin
          if (in_sequence) begin
            cur_sl_next = sat_inc(cur_sl);
          end else begin
            cur_hl_next = sat_inc(cur_hl);
          end
        end else if (!in_sequence) begin
          in_sequence_next = 1'b1;
          cur_ss_next      = op_pos;
        end
      end

      if (op_ctl.last) begin
        if (op_ctl.kind == OP_OPEN && record_open) begin
          final_pending_next = 1'b1;
        end else begin
          if (record_open_next) begin
            emit       = 1'b1;
            emit_final = 1'b1;
            e_num = record_count_next;
            e_hs  = cur_hs_next;
            e_hl  = cur_hl_next;
            e_ss  = cur_ss_next;
            e_sl  = cur_sl_next;
          end
          record_open_next  = 1'b0;
          in_sequence_next  = 1'b0;
          record_count_next = '0;
          cur_hs_next = '0;
          cur_hl_next = '0;
          cur_ss_next = '0;
          cur_sl_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_open   <= 1'b0;
      in_sequence   <= 1'b0;
      final_pending <= 1'b0;
      record_count  <= '0;
      cur_hs        <= '0;
      cur_hl        <= '0;
      cur_ss        <= '0;
      cur_sl        <= '0;
      out_valid     <= 1'b0;
    end else begin
      record_open   <= record_open_next;
      in_sequence   <= in_sequence_next;
      final_pending <= final_pending_next;
      record_count  <= record_count_next;
      cur_hs        <= cur_hs_next;
      cur_hl        <= cur_hl_next;
      cur_ss        <= cur_ss_next;
      cur_sl        <= cur_sl_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      record_number   <= e_num;
      header_start    <= OUT_POS_BITS'(e_hs);
      header_length   <= OUT_POS_BITS'(e_hl);
      sequence_start  <= OUT_POS_BITS'(e_ss);
      sequence_length <= OUT_POS_BITS'(e_sl);
      final_record    <= emit_final;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/fasta_record_scanner.sv
// Top level of the FASTA record scanner: front end, op queue and back end.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | data_byte, stream_end
//  output   | out_valid / out_ready| record_number, header_start, header_length,
//           |                      | sequence_start, sequence_length, final_record
//
// One byte per cycle sustained while the output is not stalled; the front end
// classifies a byte in the cycle it is accepted, and the back end retires one
// queued op per cycle while its output register is free and nothing is pending.
// A '>' on the last byte while a record is open yields two items: the second is
// emitted from a pending state. Reset is synchronous and needs no clearing pass;
// state is ready the cycle after. A stalled output holds the back end; the
// two-entry queue keeps taking bytes until it fills, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fasta_record_scanner #(
  parameter int unsigned POSITION_BITS = frs_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [frs_pkg::BYTE_BITS-1:0]      data_byte,
  input  wire logic                               stream_end,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [frs_pkg::RECORD_BITS-1:0]         record_number,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        header_start,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        header_length,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        sequence_start,
  output logic [frs_pkg::OUT_POS_BITS-1:0]        sequence_length,
  output logic                                    final_record
);
  import frs_pkg::*;

  localparam int unsigned CTL_BITS = $bits(op_ctl_t);
  localparam int unsigned Q_BITS   = CTL_BITS + POSITION_BITS;

  // Front-end op toward the queue.
  logic                     f_push;
  op_ctl_t                  f_ctl;
  logic [POSITION_BITS-1:0] f_pos;

  // Queue side.
  logic                     q_full;
  logic                     q_valid;
  logic [Q_BITS-1:0]        q_data;
  logic                     q_pop;
  op_ctl_t                  q_ctl;
  logic [POSITION_BITS-1:0] q_pos;

  back_stat_t               back_stat;

  assign q_ctl = op_ctl_t'(q_data[Q_BITS-1 -: CTL_BITS]);
  assign q_pos = q_data[POSITION_BITS-1:0];

  // Classify bytes and track position / line start.
  frs_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .op_push    (f_push),
    .op_ctl     (f_ctl),
    .op_pos     (f_pos),
    .op_full    (q_full)
  );

  // Hold classified ops so either side can stall on its own.
  frs_queue #(
    .WIDTH(Q_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_ctl, f_pos}),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .pop       (q_pop)
  );

  // Advance record state and emit result items.
  frs_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .op_valid        (q_valid),
    .op_ctl          (q_ctl),
    .op_pos          (q_pos),
    .op_pop          (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .record_number   (record_number),
    .header_start    (header_start),
    .header_length   (header_length),
    .sequence_start  (sequence_start),
    .sequence_length (sequence_length),
    .final_record    (final_record),
    .stat            (back_stat)
  );

  // The queue must never see a push while it is full.
  `FRS_NEVER(a_no_push_when_full, clk, rst, f_push && q_full)
  // While the second item of a stream end is pending, no op may be retired.
  `FRS_ASSERT(a_hold_queue_on_pending, clk, rst, back_stat.final_pending |-> !q_pop)
  // The pending state only starts together with the preceding record's item.
  `FRS_ASSERT(a_pending_after_emit, clk, rst, $rose(back_stat.final_pending) |-> out_valid)
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the FASTA record scanner top level.
`timescale 1ns / 1ps
module testbench;
  localparam int PB  = frs_pkg::POSITION_BITS_DEFAULT;
  localparam int OPB = frs_pkg::OUT_POS_BITS;
  localparam int RB  = frs_pkg::RECORD_BITS;
  localparam logic [7:0] MARK = frs_pkg::CHAR_MARKER;
  localparam logic [7:0] NL   = frs_pkg::CHAR_NEWLINE;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_ready;
  logic [7:0]     data_byte;
  logic           stream_end;
  logic           out_valid;
  logic           out_ready;
  logic [RB-1:0]  record_number;
  logic [OPB-1:0] header_start;
  logic [OPB-1:0] header_length;
  logic [OPB-1:0] sequence_start;
  logic [OPB-1:0] sequence_length;
  logic           final_record;

  fasta_record_scanner uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .stream_end(stream_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .record_number(record_number), .header_start(header_start),
    .header_length(header_length), .sequence_start(sequence_start),
    .sequence_length(sequence_length), .final_record(final_record)
  );

  // One reported record, as the scanner should emit it.
  typedef struct {
    logic [RB-1:0]  rec_num;
    logic [OPB-1:0] hstart;
    logic [OPB-1:0] hlen;
    logic [OPB-1:0] sstart;
    logic [OPB-1:0] slen;
    logic           closing;
  } record_info_t;

  record_info_t expected_records[$];
  logic [7:0]   stream_text[$];

  // Scanner state mirrored by the predictor.
  logic [PB-1:0] scan_pos;
  logic          line_start;
  logic          in_seq;
  logic          rec_open;
  logic [RB-1:0] rec_index;
  logic [PB-1:0] hdr_start;
  logic [PB-1:0] hdr_len;
  logic [PB-1:0] seq_start;
  logic [PB-1:0] seq_len;

  int mismatches = 0;
  int items_sent = 0;
  bit sender_idle = 1'b1;   // draw random gaps between input items
  bit sink_idle = 1'b1;     // draw random stalls between results
  int sink_hold = 0;        // one long hold-off, picked up by the sink

  // Free-running clock, 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: bail out if the run hangs.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Saturating increment for positions and lengths.
  function automatic logic [PB-1:0] bump(logic [PB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void clear_scanner();
    scan_pos   = '0;
    line_start = 1'b1;
    in_seq     = 1'b0;
    rec_open   = 1'b0;
    rec_index  = '0;
    hdr_start  = '0;
    hdr_len    = '0;
    seq_start  = '0;
    seq_len    = '0;
  endfunction

  function automatic void queue_record(logic closing);
    record_info_t r;
    r.rec_num = rec_index;
    r.hstart  = hdr_start;
    r.hlen    = hdr_len;
    r.sstart  = seq_start;
    r.slen    = seq_len;
    r.closing = closing;
    expected_records.insert(expected_records.size(), r);
  endfunction

  // Advance the mirrored state by one accepted byte; queue any records it closes.
  function automatic void scan_byte(logic [7:0] b, logic is_last);
    logic [PB-1:0] pos;
    pos = scan_pos;
    if (line_start && b == MARK) begin
      // A marker at line start closes the open record and opens a new one.
      if (rec_open) begin
        queue_record(1'b0);
        rec_index = rec_index + 1'b1;
      end
      rec_open  = 1'b1;
      in_seq    = 1'b0;
      hdr_start = bump(pos);
      hdr_len   = '0;
      seq_start = '0;
      seq_len   = '0;
    end else if (rec_open) begin
      if (b != NL) begin
        if (in_seq) seq_len = bump(seq_len);
        else hdr_len = bump(hdr_len);
      end else if (!in_seq) begin
        // First newline of the record: the sequence starts after it.
        in_seq    = 1'b1;
        seq_start = bump(pos);
      end
    end
    line_start = (b == NL);
    scan_pos   = bump(pos);
    if (is_last) begin
      if (rec_open) queue_record(1'b1);
      clear_scanner();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    record_info_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected record: num %0d hs %0d hl %0d ss %0d sl %0d end %0b",
                   record_number, header_start, header_length, sequence_start,
                   sequence_length, final_record);
        mismatches++;
      end else begin
        e = expected_records.pop_front();
        if (e.rec_num !== record_number || e.hstart !== header_start ||
            e.hlen !== header_length || e.sstart !== sequence_start ||
            e.slen !== sequence_length || e.closing !== final_record) begin
          if (mismatches < 10) begin
            $display("record mismatch: expected num %0d hs %0d hl %0d ss %0d sl %0d end %0b",
                     e.rec_num, e.hstart, e.hlen, e.sstart, e.slen, e.closing);
            $display("                 got      num %0d hs %0d hl %0d ss %0d sl %0d end %0b",
                     record_number, header_start, header_length, sequence_start,
                     sequence_length, final_record);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall per result, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold != 0) begin
        // Take the long hold-off; the scanner fills and stalls its input.
        wait_left = sink_hold;
        sink_hold = 0;
      end else if (out_valid && out_ready && sink_idle) begin
        wait_left = $urandom_range(0, 15);
      end
      if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Append one byte to the composed text.
  function automatic void add_text(logic [7:0] b);
    stream_text.insert(stream_text.size(), b);
  endfunction

  // Offer one byte and hold it until accepted; predict at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    stream_end <= is_last;
    do @(posedge clk); while (!in_ready);
    scan_byte(b, is_last);
    items_sent++;
  endtask

  // Send the composed text, marking its final byte as the stream end.
  task automatic send_text();
    foreach (stream_text[i]) send_byte(stream_text[i], i == stream_text.size() - 1);
  endtask

  // Drop valid, wait for every expected record, then allow for latency.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_records.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  // Content byte: mostly bases or printable characters, sometimes any byte but a newline.
  function automatic logic [7:0] pick_content(bit bases);
    string alphabet;
    logic [7:0] b;
    alphabet = "ACGTN";
    if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
    else if (bases) b = alphabet[$urandom_range(0, 4)];
    else b = 8'($urandom_range(32, 126));
    if (b == NL) b = "-";
    return b;
  endfunction

  // Build one FASTA stream with random content into stream_text.
  task automatic compose_fasta();
    int n_rec;
    int n_lines;
    stream_text.delete();
    // Occasional junk before the first record; ends with a newline so '>' opens.
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) add_text(pick_content(1'b0));
      add_text(NL);
    end
    n_rec = $urandom_range(1, 4);
    for (int r = 0; r < n_rec; r++) begin
      if (stream_text.size() != 0 && stream_text[$] != NL && $urandom_range(0, 9) != 0)
        add_text(NL);
      add_text(MARK);
      repeat ($urandom_range(0, 12)) add_text(pick_content(1'b0));
      if ($urandom_range(0, 9) != 0) begin
        add_text(NL);
        n_lines = $urandom_range(1, 4);
        for (int l = 0; l < n_lines; l++) begin
          repeat ($urandom_range(0, 16)) add_text(pick_content(1'b1));
          if (l < n_lines - 1 || $urandom_range(0, 1) == 0) add_text(NL);
        end
      end
    end
    // Sometimes end the stream on a marker that opens an empty record.
    if ($urandom_range(0, 5) == 0) begin
      if (stream_text[$] != NL) add_text(NL);
      add_text(MARK);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked streams covering each corner of the scan rules.
  task automatic test_directed();
    // Stream end with no record open: nothing reported.
    send_byte("x", 1'b0);
    send_byte(NL, 1'b1);
    // Junk before the first record, a '>' inside a header, multi-line sequence.
    send_byte("z", 1'b0);
    send_byte(NL, 1'b0);
    send_byte(MARK, 1'b0);
    send_byte("h", 1'b0);
    send_byte(MARK, 1'b0);
    send_byte(NL, 1'b0);
    send_byte("A", 1'b0);
    send_byte(NL, 1'b0);
    send_byte("G", 1'b1);
    // Marker on the last byte: previous record, then an empty final one.
    send_byte(MARK, 1'b0);
    send_byte(NL, 1'b0);
    send_byte(MARK, 1'b1);
    // Byte extremes, an empty line, and a closing record with no newline.
    send_byte(MARK, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(NL, 1'b0);
    send_byte(NL, 1'b0);
    send_byte("T", 1'b0);
    send_byte(NL, 1'b0);
    send_byte(MARK, 1'b0);
    send_byte("Q", 1'b0);
    send_byte(8'h80, 1'b1);
    // A lone marker that is also the last byte.
    send_byte(MARK, 1'b1);
    drain_results();
  endtask

  // Mostly well-formed streams, with stretches of idling switched on and off.
  task automatic test_well_formed();
    int start;
    start = items_sent;
    while (items_sent - start < 580) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      compose_fasta();
      send_text();
    end
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    drain_results();
  endtask

  // Hold the sink off while many short records stream in back to back.
  task automatic test_backpressure();
    sender_idle = 1'b0;
    sink_hold   = 400;
    stream_text.delete();
    repeat (25) begin
      add_text(MARK);
      add_text(pick_content(1'b0));
      add_text(NL);
    end
    send_text();
    sender_idle = 1'b1;
    drain_results();
  endtask

  // Random bytes rich in markers and newlines, with random stream ends.
  task automatic test_noise();
    logic [7:0] b;
    for (int i = 0; i < 160; i++) begin
      case ($urandom_range(0, 9))
        0:       b = MARK;
        1, 2:    b = NL;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == 159 || $urandom_range(0, 24) == 0);
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = '0;
    stream_end = 1'b0;
    clear_scanner();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_well_formed();
    test_backpressure();
    test_noise();

    // Anything still expected never arrived.
    mismatches += expected_records.size();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
